>>> hw/rtl/nnis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int MAX_DIM     = 64;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 7;    // source width / height register
  localparam int RATIO_W     = 8;    // numerator / denominator register
  localparam int DEST_W      = 14;   // destination extent, also divider dividend
  localparam int MUL_W       = 16;   // address product
  localparam int CNT_W       = $clog2(DEST_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE_NUM  = 2'd2,
    CFG_SCALE_DEN  = 2'd3
  } cfg_idx_e;

  // divider jobs run once per configuration
  typedef enum logic [1:0] {
    JOB_DEST_W   = 2'd0,
    JOB_DEST_H   = 2'd1,
    JOB_STEP     = 2'd2,
    JOB_START    = 2'd3
  } job_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_READ = 4'b0100,
    ST_SEND = 4'b1000
  } state_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EMIT = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        row_end;
    logic        frame_end;
  } out_item_t;

endpackage

>>> hw/rtl/nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor resize of a stored source frame by num/den.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o): func = load writes pixel_in into
//   the frame store at the next raster position; func = emit returns the next
//   destination pixel in raster order with row_end / frame_end flags
//   output channel (out_valid_o / out_stall_i): one transfer per emit into a non-empty destination
//   config channel (cfg_valid_i / cfg_ready_o): always ready; any write
//   restarts the destination scan and the load position
// sequencing
//   a load is written in the cycle it is taken; an emit passes accept, store read
//   and output register, with in_stall_o high until its result is registered
//   after reset or a config write the shared divider computes the destination
//   size, step and start phase in 4 jobs, with in_stall_o high throughout;
//   the same holds at reset
// stall
//   a result waits in the output register while out_stall_i is high; the next
//   item is still taken and waits in the send state until the register frees
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  // config writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // config registers
  logic [DIM_W-1:0]   src_width_q, src_height_q;
  logic [RATIO_W-1:0] num_q, den_q;

  // sequencer
  state_e state_q, state_d;
  job_e   job_q;
  logic   div_load_q;

  // shared divider
  logic [DEST_W-1:0]  div_quo_q, div_quo_d;
  logic [RATIO_W-1:0] div_rem_q, div_rem_d;
  logic [CNT_W-1:0]   div_cnt_q;
  logic [DEST_W-1:0]  div_dividend;
  logic [RATIO_W-1:0] div_divisor;
  logic [RATIO_W:0]   div_shift;

  // derived per-configuration values
  logic [DEST_W-1:0]  dest_w_q, dest_h_q;
  logic [RATIO_W-1:0] step_whole_q, step_frac_q;
  logic [RATIO_W-1:0] init_whole_q, init_frac_q;

  // scan state
  logic [ADDR_W-1:0]  load_idx_q;
  logic [DEST_W-1:0]  dest_col_q, dest_row_q;
  logic [RATIO_W-1:0] col_whole_q, col_frac_q, row_whole_q, row_frac_q;

  // emit datapath
  logic [ADDR_W-1:0]  addr_q;
  logic               row_end_q, frame_end_q;
  logic [31:0]        rd_data_q;
  logic [31:0]        store_mem [STORE_DEPTH];

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  // effective config values
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [RATIO_W-1:0] den_eff, start_phase;

  logic cfg_we, in_accept, load_we, emit_go, dest_empty, out_load;
  logic row_end, frame_end;
  logic [MUL_W-1:0] addr_full;
  logic [2*RATIO_W-1:0] col_next, row_next;

  // one phase step: whole + den/num, fraction counted in 1/num units
  function automatic logic [2*RATIO_W-1:0] phase_step(
    input logic [RATIO_W-1:0] whole,
    input logic [RATIO_W-1:0] frac,
    input logic [RATIO_W-1:0] sw,
    input logic [RATIO_W-1:0] sf,
    input logic [RATIO_W-1:0] num
  );
    logic [RATIO_W:0]   f;
    logic [RATIO_W-1:0] w;
    f = {1'b0, frac} + {1'b0, sf};
    w = whole + sw;
    if (f >= {1'b0, num}) begin
      f = f - {1'b0, num};
      w = w + 1'b1;
    end
    return {w, f[RATIO_W-1:0]};
  endfunction

  assign w_eff   = (src_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_width_q;
  assign h_eff   = (src_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_height_q;
  assign den_eff = (den_q == '0) ? RATIO_W'(1) : den_q;
  // downscaling starts half a source step in
  assign start_phase = (num_q < den_eff) ? {1'b0, den_eff[RATIO_W-1:1]} : '0;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign load_we     = in_accept && (in_data_i.func == FUNC_LOAD);
  assign dest_empty  = (dest_w_q == '0) || (dest_h_q == '0);
  // an emit into an empty destination is taken and dropped
  assign emit_go     = in_accept && (in_data_i.func == FUNC_EMIT) && !dest_empty;
  assign out_load    = (state_q == ST_SEND) && (!out_valid_q || !out_stall_i);

  // divider operands per job
  always_comb begin
    div_dividend = DEST_W'(start_phase);
    div_divisor  = num_q;
    case (job_q)
      JOB_DEST_W: begin
        div_dividend = DEST_W'(w_eff) * DEST_W'(num_q);
        div_divisor  = den_eff;
      end
      JOB_DEST_H: begin
        div_dividend = DEST_W'(h_eff) * DEST_W'(num_q);
        div_divisor  = den_eff;
      end
      JOB_STEP: begin
        div_dividend = DEST_W'(den_eff);
        div_divisor  = num_q;
      end
      JOB_START: begin
        div_dividend = DEST_W'(start_phase);
        div_divisor  = num_q;
      end
      default: begin
        div_dividend = DEST_W'(start_phase);
        div_divisor  = num_q;
      end
    endcase
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    div_shift = {div_rem_q, div_quo_q[DEST_W-1]};
    div_quo_d = {div_quo_q[DEST_W-2:0], 1'b0};
    div_rem_d = div_shift[RATIO_W-1:0];
    if (div_shift >= {1'b0, div_divisor}) begin
      div_rem_d    = RATIO_W'(div_shift - {1'b0, div_divisor});
      div_quo_d[0] = 1'b1;
    end
  end

  // emit bookkeeping, taken from the scan state before the step
  assign addr_full = MUL_W'(row_whole_q) * MUL_W'(w_eff) + MUL_W'(col_whole_q);
  assign row_end   = (dest_col_q == dest_w_q - 1'b1);
  assign frame_end = row_end && (dest_row_q == dest_h_q - 1'b1);
  assign col_next  = phase_step(col_whole_q, col_frac_q, step_whole_q, step_frac_q, num_q);
  assign row_next  = phase_step(row_whole_q, row_frac_q, step_whole_q, step_frac_q, num_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (emit_go) begin
          state_d = ST_READ;
        end
      end
      ST_PREP: begin
        if (!div_load_q && div_cnt_q == CNT_W'(DEST_W - 1) && job_q == JOB_START) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_PREP;
      end
    endcase
    if (cfg_we) begin
      state_d = ST_PREP;
    end
  end

  // control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DIM_W'(64);
      src_height_q <= DIM_W'(64);
      num_q        <= RATIO_W'(1);
      den_q        <= RATIO_W'(1);
      state_q      <= ST_PREP;
      job_q        <= JOB_DEST_W;
      div_load_q   <= 1'b1;
      div_cnt_q    <= '0;
      load_idx_q   <= '0;
      dest_col_q   <= '0;
      dest_row_q   <= '0;
      col_whole_q  <= '0;
      col_frac_q   <= '0;
      row_whole_q  <= '0;
      row_frac_q   <= '0;
      dest_w_q     <= '0;
      dest_h_q     <= '0;
      step_whole_q <= '0;
      step_frac_q  <= '0;
      init_whole_q <= '0;
      init_frac_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (load_we) begin
        load_idx_q <= load_idx_q + 1'b1;
      end

      if (state_q == ST_PREP) begin
        if (div_load_q) begin
          div_load_q <= 1'b0;
          div_cnt_q  <= '0;
        end else begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == CNT_W'(DEST_W - 1)) begin
            div_load_q <= 1'b1;
            case (job_q)
              JOB_DEST_W: begin
                dest_w_q <= div_quo_d;
                job_q    <= JOB_DEST_H;
              end
              JOB_DEST_H: begin
                dest_h_q <= div_quo_d;
                job_q    <= JOB_STEP;
              end
              JOB_STEP: begin
                step_whole_q <= div_quo_d[RATIO_W-1:0];
                step_frac_q  <= div_rem_d;
                job_q        <= JOB_START;
              end
              JOB_START: begin
                // divider done: start the scan at its initial phase
                init_whole_q <= div_quo_d[RATIO_W-1:0];
                init_frac_q  <= div_rem_d;
                col_whole_q  <= div_quo_d[RATIO_W-1:0];
                col_frac_q   <= div_rem_d;
                row_whole_q  <= div_quo_d[RATIO_W-1:0];
                row_frac_q   <= div_rem_d;
                dest_col_q   <= '0;
                dest_row_q   <= '0;
                job_q        <= JOB_DEST_W;
              end
              default: begin
                job_q <= JOB_DEST_W;
              end
            endcase
          end
        end
      end

      if (emit_go) begin
        if (!row_end) begin
          dest_col_q  <= dest_col_q + 1'b1;
          col_whole_q <= col_next[2*RATIO_W-1:RATIO_W];
          col_frac_q  <= col_next[RATIO_W-1:0];
        end else if (frame_end) begin
          // frame wrap
          dest_col_q  <= '0;
          dest_row_q  <= '0;
          col_whole_q <= init_whole_q;
          col_frac_q  <= init_frac_q;
          row_whole_q <= init_whole_q;
          row_frac_q  <= init_frac_q;
        end else begin
          dest_col_q  <= '0;
          col_whole_q <= init_whole_q;
          col_frac_q  <= init_frac_q;
          dest_row_q  <= dest_row_q + 1'b1;
          row_whole_q <= row_next[2*RATIO_W-1:RATIO_W];
          row_frac_q  <= row_next[RATIO_W-1:0];
        end
      end

      if (cfg_we) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[DIM_W-1:0];
          CFG_SCALE_NUM:  num_q        <= cfg_data_i;
          CFG_SCALE_DEN:  den_q        <= cfg_data_i;
          default:        num_q        <= num_q;
        endcase
        load_idx_q <= '0;
        job_q      <= JOB_DEST_W;
        div_load_q <= 1'b1;
      end
    end
  end

  // divider datapath, loaded at the start of each job
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      if (div_load_q) begin
        div_quo_q <= div_dividend;
        div_rem_q <= '0;
      end else begin
        div_quo_q <= div_quo_d;
        div_rem_q <= div_rem_d;
      end
    end
  end

  // emit payload path
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      addr_q      <= addr_full[ADDR_W-1:0];
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
    end
    if (out_load) begin
      out_data_q.pixel_out <= rd_data_q;
      out_data_q.row_end   <= row_end_q;
      out_data_q.frame_end <= frame_end_q;
    end
  end

  // frame store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      store_mem[load_idx_q] <= in_data_i.pixel_in;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= store_mem[addr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
